### sv/blake3_compression_macros.svh
// Assertion macros for the BLAKE3 compression core.
`ifndef BLAKE3_COMPRESSION_MACROS_SVH
`define BLAKE3_COMPRESSION_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define BLK3_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define BLK3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/blk3_pkg.sv
// Shared types, constants and schedule table for the BLAKE3 compression core.
package blk3_pkg;

  localparam int NumRounds = 7;

  localparam logic [1:0] KIND_CV    = 2'd0;
  localparam logic [1:0] KIND_MSG   = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;

  localparam logic [31:0] IV0 = 32'h6A09E667;
  localparam logic [31:0] IV1 = 32'hBB67AE85;
  localparam logic [31:0] IV2 = 32'h3C6EF372;
  localparam logic [31:0] IV3 = 32'hA54FF53A;

  localparam logic [3:0] SCHED [NumRounds][16] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd2, 4'd6, 4'd3, 4'd10, 4'd7, 4'd0, 4'd4, 4'd13,
      4'd1, 4'd11, 4'd12, 4'd5, 4'd9, 4'd14, 4'd15, 4'd8},
    '{4'd3, 4'd4, 4'd10, 4'd12, 4'd13, 4'd2, 4'd7, 4'd14,
      4'd6, 4'd5, 4'd9, 4'd0, 4'd11, 4'd15, 4'd8, 4'd1},
    '{4'd10, 4'd7, 4'd12, 4'd9, 4'd14, 4'd3, 4'd13, 4'd15,
      4'd4, 4'd0, 4'd11, 4'd2, 4'd5, 4'd8, 4'd1, 4'd6},
    '{4'd12, 4'd13, 4'd9, 4'd11, 4'd15, 4'd10, 4'd14, 4'd8,
      4'd7, 4'd2, 4'd5, 4'd3, 4'd0, 4'd1, 4'd6, 4'd4},
    '{4'd9, 4'd14, 4'd11, 4'd5, 4'd8, 4'd12, 4'd15, 4'd1,
      4'd13, 4'd3, 4'd0, 4'd10, 4'd2, 4'd6, 4'd4, 4'd7},
    '{4'd11, 4'd15, 4'd5, 4'd0, 4'd1, 4'd9, 4'd8, 4'd6,
      4'd14, 4'd10, 4'd2, 4'd12, 4'd3, 4'd4, 4'd7, 4'd13}
  };

  // Four state words that one G application works on.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } quad_t;

  function automatic logic [3:0] sched_pos(input logic [2:0] rnd, input logic [3:0] pos);
    return SCHED[rnd][pos];
  endfunction

endpackage

### sv/blk3_g_half.sv
// One half of the BLAKE3 G function: add, xor-rotate, add, xor-rotate.
module blk3_g_half (
  input  blk3_pkg::quad_t q_in,
  input  logic [31:0]     m,
  input  logic            second,
  output blk3_pkg::quad_t q_out
);
  import blk3_pkg::*;

  logic [31:0] a1, dx, d1, c1, bx, b1;

  always_comb begin
    a1 = q_in.a + q_in.b + m;
    dx = q_in.d ^ a1;
    d1 = second ? {dx[7:0], dx[31:8]} : {dx[15:0], dx[31:16]};
    c1 = q_in.c + d1;
    bx = q_in.b ^ c1;
    b1 = second ? {bx[6:0], bx[31:7]} : {bx[11:0], bx[31:12]};
    q_out.a = a1;
    q_out.b = b1;
    q_out.c = c1;
    q_out.d = d1;
  end

endmodule

### sv/blake3_compression.sv
// Top level of the BLAKE3 compression core: word stores, sequencer and output shifter.
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------------------------
//   in      | in_valid / in_stall | kind, index, word, counter, block_length,
//           |                     | domain_flags
//   out     | out_valid/out_stall | out_index, out_word, last
//
// A start item sets up the state, runs 56 G steps of mixing (one half G per cycle through
// the shared G unit), folds the result, then sends 16 output items; in_stall is high
// until the last leaves.
// rst is synchronous, clears the sequencer and holds both channels shut while high;
// the word stores hold nothing until loaded.
// out_stall holds the current output word and index in place.
module blake3_compression (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [3:0]  index,
  input  logic [31:0] word,
  input  logic [63:0] counter,
  input  logic [6:0]  block_length,
  input  logic [4:0]  domain_flags,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_index,
  output logic [31:0] out_word,
  output logic        last
);
  import blk3_pkg::*;

  typedef enum logic [1:0] {IDLE, MIX, FOLD, SEND} state_t;

  state_t      state;
  logic [2:0]  rnd;
  logic [2:0]  step;
  logic        half;
  logic [3:0]  ocnt;
  logic [31:0] v [16];
  logic [31:0] cv [8];
  logic [31:0] msg [16];

  logic        in_acc, out_acc, diag;
  logic [31:0] m_word;
  quad_t       q_in, q_out;
  logic [31:0] vw [16];
  logic [31:0] v_next [16];

  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign in_stall  = rst || (state != IDLE);
  assign out_valid = !rst && (state == SEND);
  assign out_word  = v[0];
  assign out_index = ocnt;
  assign last      = (ocnt == 4'd15);

  // Word stores.
  always_ff @(posedge clk) begin
    if (in_acc && kind == KIND_CV && !index[3]) begin
      cv[index[2:0]] <= word;
    end
    if (in_acc && kind == KIND_MSG) begin
      msg[index] <= word;
    end
  end

  assign m_word = msg[sched_pos(rnd, {step, half})];

  // Columns use positions 0,4,8,12, diagonals 0,5,10,15; rows rotate after each G.
  assign diag   = step[2];
  assign q_in.a = v[0];
  assign q_in.b = diag ? v[5]  : v[4];
  assign q_in.c = diag ? v[10] : v[8];
  assign q_in.d = diag ? v[15] : v[12];

  blk3_g_half u_g (
    .q_in  (q_in),
    .m     (m_word),
    .second(half),
    .q_out (q_out)
  );

  always_comb begin
    vw = v;
    vw[0] = q_out.a;
    if (diag) begin
      vw[5]  = q_out.b;
      vw[10] = q_out.c;
      vw[15] = q_out.d;
    end else begin
      vw[4]  = q_out.b;
      vw[8]  = q_out.c;
      vw[12] = q_out.d;
    end
    for (int r = 0; r < 4; r++) begin
      for (int j = 0; j < 4; j++) begin
        v_next[4*r + j] = half ? vw[4*r + ((j + 1) % 4)] : vw[4*r + j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      rnd   <= '0;
      step  <= '0;
      half  <= 1'b0;
      ocnt  <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (in_acc && kind == KIND_START) begin
            for (int i = 0; i < 8; i++) begin
              v[i] <= cv[i];
            end
            v[8]  <= IV0;
            v[9]  <= IV1;
            v[10] <= IV2;
            v[11] <= IV3;
            v[12] <= counter[31:0];
            v[13] <= counter[63:32];
            v[14] <= {25'd0, block_length};
            v[15] <= {27'd0, domain_flags};
            rnd   <= '0;
            step  <= '0;
            half  <= 1'b0;
            state <= MIX;
          end
        end
        MIX: begin
          v    <= v_next;
          half <= ~half;
          if (half) begin
            step <= step + 3'd1;
            if (step == 3'd7) begin
              if (rnd == 3'(NumRounds - 1)) begin
                state <= FOLD;
              end else begin
                rnd <= rnd + 3'd1;
              end
            end
          end
        end
        FOLD: begin
          for (int i = 0; i < 8; i++) begin
            v[i]     <= v[i] ^ v[i + 8];
            v[i + 8] <= v[i + 8] ^ cv[i];
          end
          ocnt  <= '0;
          state <= SEND;
        end
        SEND: begin
          if (out_acc) begin
            for (int i = 0; i < 15; i++) begin
              v[i] <= v[i + 1];
            end
            ocnt <= ocnt + 4'd1;
            if (ocnt == 4'd15) begin
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`include "blake3_compression_macros.svh"

  `BLK3_ASSERT_NOW(a_no_overlap, !in_stall, !out_valid, "input open while output pending")
  `BLK3_ASSERT_NEXT(a_start_busy, in_acc && kind == KIND_START, in_stall && !out_valid, "start did not enter mixing")
  `BLK3_ASSERT_NEXT(a_last_frees, out_acc && last, !in_stall && !out_valid, "block not free after last item")
  `BLK3_ASSERT_NEXT(a_index_step, out_acc && !last, out_valid && out_index == ($past(out_index) + 4'd1), "output index skipped")

endmodule

### sim/tb.sv
// Self-checking testbench for the BLAKE3 compression core: word loads, starts and output words.
`timescale 1ns / 1ps

module tb;
  import blk3_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned MSG_PERM [16] = '{2, 6, 3, 10, 7, 0, 4, 13,
                                            1, 11, 12, 5, 9, 14, 15, 8};

  typedef struct {
    logic [3:0]  pos;
    logic [31:0] value;
    logic        is_last;
  } out_word_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  kind;
  logic [3:0]  index;
  logic [31:0] word;
  logic [63:0] counter;
  logic [6:0]  block_length;
  logic [4:0]  domain_flags;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_index;
  logic [31:0] out_word;
  logic        last;

  logic [31:0] cv_store [8];
  logic [31:0] msg_store [16];
  out_word_t   expected_words [$];
  int          err_count;
  int          send_idle_pct;
  int          recv_stall_pct;

  blake3_compression i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .index        (index),
    .word         (word),
    .counter      (counter),
    .block_length (block_length),
    .domain_flags (domain_flags),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_index    (out_index),
    .out_word     (out_word),
    .last         (last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(4_000_000);
    $display("[blake3_compression] ERROR");
    $finish;
  end

  function automatic logic [31:0] rotr(input logic [31:0] x, input int s);
    return (x >> s) | (x << (32 - s));
  endfunction

  function automatic quad_t g_mix(input quad_t q, input logic [31:0] m0, input logic [31:0] m1);
    quad_t r;
    r = q;
    r.a = r.a + r.b + m0;
    r.d = rotr(r.d ^ r.a, 16);
    r.c = r.c + r.d;
    r.b = rotr(r.b ^ r.c, 12);
    r.a = r.a + r.b + m1;
    r.d = rotr(r.d ^ r.a, 8);
    r.c = r.c + r.d;
    r.b = rotr(r.b ^ r.c, 7);
    return r;
  endfunction

  task automatic predict_block(input logic [63:0] ctr, input logic [6:0] blen,
                               input logic [4:0] flg);
    logic [31:0] v [16];
    logic [31:0] m [16];
    logic [31:0] mp [16];
    out_word_t   e;
    int          i;
    int          r;
    for (i = 0; i < 8; i++) v[i] = cv_store[i];
    v[8]  = IV0;
    v[9]  = IV1;
    v[10] = IV2;
    v[11] = IV3;
    v[12] = ctr[31:0];
    v[13] = ctr[63:32];
    v[14] = {25'd0, blen};
    v[15] = {27'd0, flg};
    for (i = 0; i < 16; i++) m[i] = msg_store[i];
    for (r = 0; r < NumRounds; r++) begin
      {v[0], v[4], v[8],  v[12]} = g_mix({v[0], v[4], v[8],  v[12]}, m[0],  m[1]);
      {v[1], v[5], v[9],  v[13]} = g_mix({v[1], v[5], v[9],  v[13]}, m[2],  m[3]);
      {v[2], v[6], v[10], v[14]} = g_mix({v[2], v[6], v[10], v[14]}, m[4],  m[5]);
      {v[3], v[7], v[11], v[15]} = g_mix({v[3], v[7], v[11], v[15]}, m[6],  m[7]);
      {v[0], v[5], v[10], v[15]} = g_mix({v[0], v[5], v[10], v[15]}, m[8],  m[9]);
      {v[1], v[6], v[11], v[12]} = g_mix({v[1], v[6], v[11], v[12]}, m[10], m[11]);
      {v[2], v[7], v[8],  v[13]} = g_mix({v[2], v[7], v[8],  v[13]}, m[12], m[13]);
      {v[3], v[4], v[9],  v[14]} = g_mix({v[3], v[4], v[9],  v[14]}, m[14], m[15]);
      for (i = 0; i < 16; i++) mp[i] = m[MSG_PERM[i]];
      for (i = 0; i < 16; i++) m[i] = mp[i];
    end
    for (i = 0; i < 8; i++) begin
      v[i]     = v[i] ^ v[i + 8];
      v[i + 8] = v[i + 8] ^ cv_store[i];
    end
    for (i = 0; i < 16; i++) begin
      e.pos     = 4'(i);
      e.value   = v[i];
      e.is_last = (i == 15);
      expected_words.push_back(e);
    end
  endtask

  task automatic track_item(input logic [1:0] k, input logic [3:0] idx, input logic [31:0] w,
                            input logic [63:0] ctr, input logic [6:0] blen,
                            input logic [4:0] flg);
    case (k)
      KIND_CV: begin
        if (idx < 4'd8) cv_store[idx[2:0]] = w;
      end
      KIND_MSG: begin
        msg_store[idx] = w;
      end
      KIND_START: begin
        predict_block(ctr, blen, flg);
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [1:0] k, input logic [3:0] idx, input logic [31:0] w,
                           input logic [63:0] ctr, input logic [6:0] blen,
                           input logic [4:0] flg);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    kind         <= k;
    index        <= idx;
    word         <= w;
    counter      <= ctr;
    block_length <= blen;
    domain_flags <= flg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_item(k, idx, w, ctr, blen, flg);
  endtask

  task automatic load_cv(input logic [3:0] idx, input logic [31:0] w);
    send_item(KIND_CV, idx, w, {$urandom, $urandom}, 7'($urandom), 5'($urandom));
  endtask

  task automatic load_msg(input logic [3:0] idx, input logic [31:0] w);
    send_item(KIND_MSG, idx, w, {$urandom, $urandom}, 7'($urandom), 5'($urandom));
  endtask

  task automatic start_block(input logic [63:0] ctr, input logic [6:0] blen,
                             input logic [4:0] flg);
    send_item(KIND_START, 4'($urandom), $urandom, ctr, blen, flg);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // all 24 words must be written before the first start
  task automatic test_full_load;
    int i;
    for (i = 0; i < 8; i++)
      load_cv(4'(i), (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom);
    for (i = 0; i < 16; i++)
      load_msg(4'(i), (i == 0) ? 32'hFFFF_FFFF : (i == 15) ? 32'h0 : $urandom);
    start_block(64'd0, 7'd0, 5'd0);
  endtask

  task automatic test_start_extremes;
    start_block(64'hFFFF_FFFF_FFFF_FFFF, 7'd64, 5'h1F);
    start_block(64'h0000_0000_FFFF_FFFF, 7'd127, 5'h01);
    start_block(64'hFFFF_FFFF_0000_0000, 7'd1, 5'h10);
    start_block({$urandom, $urandom}, 7'd65, 5'h0A);
  endtask

  task automatic test_ignored_items;
    load_cv(4'd8, 32'hFFFF_FFFF);
    load_cv(4'd15, $urandom);
    send_item(KIND_UNUSED, 4'($urandom), $urandom, {$urandom, $urandom},
              7'($urandom), 5'($urandom));
    load_msg(4'd15, 32'hFFFF_FFFF);
    load_cv(4'd7, 32'h0);
    start_block({$urandom, $urandom}, 7'd64, 5'h0B);
  endtask

  task automatic test_random_blocks(input int n_items);
    int sent;
    int choice;
    int n;
    int i;
    logic [6:0] blen;
    sent = 0;
    while (sent < n_items) begin
      choice = $urandom_range(9);
      if (choice < 3) begin
        for (i = 0; i < 8; i++) load_cv(4'(i), $urandom);
        for (i = 0; i < 16; i++) load_msg(4'(i), $urandom);
        sent += 24;
      end else if (choice < 8) begin
        n = $urandom_range(6, 1);
        for (i = 0; i < n; i++) begin
          if ($urandom_range(2) == 0) load_cv(4'($urandom_range(7)), $urandom);
          else load_msg(4'($urandom), $urandom);
        end
        sent += n;
      end
      if ($urandom_range(4) == 0) begin
        if ($urandom_range(1) == 0)
          send_item(KIND_UNUSED, 4'($urandom), $urandom, {$urandom, $urandom},
                    7'($urandom), 5'($urandom));
        else
          load_cv(4'($urandom_range(15, 8)), $urandom);
      end
      blen = ($urandom_range(4) == 0) ? 7'($urandom_range(127, 65)) : 7'($urandom_range(64));
      start_block(($urandom_range(3) == 0) ? 64'($urandom_range(15)) : {$urandom, $urandom},
                  blen, 5'($urandom));
      sent += 1;
    end
  endtask

  always @(posedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    out_word_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("unexpected output item: out_index %0d out_word %h", out_index, out_word);
        err_count++;
      end else begin
        e = expected_words.pop_front();
        if (out_index !== e.pos) begin
          $error("out_index: expected %0d, got %0d", e.pos, out_index);
          err_count++;
        end
        if (out_word !== e.value) begin
          $error("out_word: expected %h, got %h", e.value, out_word);
          err_count++;
        end
        if (last !== e.is_last) begin
          $error("last: expected %0b, got %0b", e.is_last, last);
          err_count++;
        end
      end
    end
  end

  initial begin
    err_count      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst            = 1'b1;
    in_valid       = 1'b0;
    kind           = KIND_CV;
    index          = 4'd0;
    word           = 32'd0;
    counter        = 64'd0;
    block_length   = 7'd0;
    domain_flags   = 5'd0;
    out_stall      = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_full_load;
    test_start_extremes;
    test_ignored_items;

    set_idling(0, 0);
    test_random_blocks(50);
    set_idling(46, 0);
    test_random_blocks(50);
    set_idling(0, 46);
    test_random_blocks(50);
    set_idling(31, 31);
    test_random_blocks(50);

    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (err_count == 0 && expected_words.size() == 0) begin
      $display("[blake3_compression] OK");
    end else begin
      $display("[blake3_compression] ERROR");
    end
    $finish;
  end

endmodule
